// File: sv/semantic_ray_cost_accumulator_core_assert.svh
// Assertion macros shared by the semantic ray cost accumulator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SEMANTIC_RAY_COST_ACCUMULATOR_CORE_ASSERT_SVH
`define SEMANTIC_RAY_COST_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SRCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srca assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SRCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srca assertion failed");

`endif

// File: sv/srca_pkg.sv
// Types, widths and constants of the semantic ray cost accumulator.
// Depends on nothing; used by every module of the block.
package srca_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int SUM_W      = 48;
    localparam int COEF_W     = 10;
    localparam int MULT_W     = 3;
    localparam int CLASS_W    = 4;
    localparam int COST_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int EDGE_W     = 24;
    localparam int PROD_W     = COEF_W + MULT_W;

    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(10);

    // Dividend widths of the per-cell term and of the segment mean.
    localparam int TERM_DW  = PROD_W + FRAC_BITS - 1;
    localparam int MEAN_DW  = SUM_W - FRAC_BITS;
    localparam int DIV_RAW  = (TERM_DW > MEAN_DW) ? TERM_DW : MEAN_DW;
    localparam int DIV_W    = DIV_RAW + (DIV_RAW % 2);
    localparam int DVS_W    = (COST_W > COUNT_BITS + 1) ? COST_W : COUNT_BITS + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int STEP_W   = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX   = '1;
    localparam logic [EDGE_W-1:0]     EDGE_MAX  = '1;

    // Item kinds.
    localparam logic [FUNC_W-1:0] FUNC_CROSS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

    // Twice the class multiplier; zero marks an unweighted class.
    localparam logic [MULT_W-1:0] CLASS_MULT2 [16] = '{
        3'd0, 3'd2, 3'd6, 3'd5, 3'd2, 3'd3, 3'd3, 3'd4,
        3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    typedef struct packed {
        logic [FUNC_W-1:0] kind;
        logic              weighted;
        logic              zero_cost;
        logic [COST_W-1:0] cost;
        logic [PROD_W-1:0] numer;
    } cell_cmd_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TERM,
        BK_POST,
        BK_MEAN,
        BK_OUT
    } back_state_t;

endpackage

// File: sv/srca_front.sv
// Front end: input transfer, weight register and cell classification.
// Depends on srca_pkg; feeds srca_queue.
module srca_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [srca_pkg::COEF_W-1:0]   cfg_data,
    output logic                          cfg_ready,
    input  logic                          s_tvalid,
    input  logic [23:0]                   s_tdata,   // cell_class[3:0], cell_cost[19:4]
    input  logic [srca_pkg::FUNC_W-1:0]   s_tuser,   // func[1:0]
    output logic                          s_tready,
    input  logic                          q_full,
    output logic                          q_push,
    output srca_pkg::cell_cmd_t           q_push_data
);

    logic [srca_pkg::COEF_W-1:0]  weight_coef_reg;
    logic [srca_pkg::COEF_W-1:0]  weight_coef_next;
    logic [srca_pkg::CLASS_W-1:0] cell_class;
    logic [srca_pkg::COST_W-1:0]  cell_cost;
    logic [srca_pkg::MULT_W-1:0]  mult2;
    logic                         known_func;

    assign cfg_ready = 1'b1;
    assign weight_coef_next = (cfg_valid && cfg_ready) ? cfg_data : weight_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_coef_reg <= srca_pkg::COEF_RESET;
        end else begin
            weight_coef_reg <= weight_coef_next;
        end
    end

    assign cell_class = s_tdata[3:0];
    assign cell_cost  = s_tdata[19:4];
    assign mult2      = srca_pkg::CLASS_MULT2[cell_class];

    // Drop the unused kind here so the back end never sees it.
    assign known_func = (s_tuser == srca_pkg::FUNC_CROSS) ||
                        (s_tuser == srca_pkg::FUNC_START) ||
                        (s_tuser == srca_pkg::FUNC_END);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && known_func;

    always_comb begin
        q_push_data.kind      = s_tuser;
        q_push_data.weighted  = (mult2 != '0);
        q_push_data.zero_cost = (cell_cost == '0);
        q_push_data.cost      = cell_cost;
        q_push_data.numer     = srca_pkg::PROD_W'(weight_coef_reg) *
                                srca_pkg::PROD_W'(mult2);
    end

endmodule

// File: sv/srca_queue.sv
// Short command queue between the front end and the back end.
// Depends on srca_pkg for the command type and depth.
module srca_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  srca_pkg::cell_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output srca_pkg::cell_cmd_t pop_data,
    output logic                empty
);

    srca_pkg::cell_cmd_t            entries_reg [srca_pkg::QUEUE_DEPTH];
    logic [srca_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [srca_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [srca_pkg::PTR_W:0]       count_reg, count_next;

    assign full     = (count_reg == (srca_pkg::PTR_W + 1)'(srca_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/srca_div.sv
// Shared restoring divider, two quotient bits per cycle.
// Depends on srca_pkg; used by srca_back for cell terms and the segment mean.
module srca_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  srca_pkg::div_req_t req,
    output srca_pkg::div_rsp_t rsp
);

    logic [srca_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [srca_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [srca_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [srca_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [srca_pkg::DVS_W:0]    t1, r1, t2, r2;
    logic                        ge1, ge2;

    always_comb begin
        t1  = {rem_reg, quo_reg[srca_pkg::DIV_W-1]};
        ge1 = (t1 >= {1'b0, dvs_reg});
        r1  = ge1 ? (t1 - {1'b0, dvs_reg}) : t1;
        t2  = {r1[srca_pkg::DVS_W-1:0], quo_reg[srca_pkg::DIV_W-2]};
        ge2 = (t2 >= {1'b0, dvs_reg});
        r2  = ge2 ? (t2 - {1'b0, dvs_reg}) : t2;

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = srca_pkg::STEP_W'(srca_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = r2[srca_pkg::DVS_W-1:0];
            quo_next = {quo_reg[srca_pkg::DIV_W-3:0], ge1, ge2};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == srca_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // Quotient holds until the next start.
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: sv/srca_back.sv
// Back end: accumulates cell terms, forms the segment mean, holds the result.
// Depends on srca_pkg and the assertion header; drives srca_div.
`include "semantic_ray_cost_accumulator_core_assert.svh"

module srca_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  srca_pkg::cell_cmd_t         q_data,
    output logic                        q_pop,
    output srca_pkg::div_req_t          div_req,
    input  srca_pkg::div_rsp_t          div_rsp,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [srca_pkg::EDGE_W-1:0] m_tdata,
    output logic                        m_tuser
);

    srca_pkg::back_state_t               state_reg, state_next;
    srca_pkg::cell_cmd_t                 cmd_reg, cmd_next;
    logic [srca_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [srca_pkg::COUNT_BITS-1:0]     count_reg, count_next;
    logic                                zero_reg, zero_next;
    logic                                out_valid_reg, out_valid_next;
    logic [srca_pkg::EDGE_W-1:0]         out_edge_reg, out_edge_next;
    logic                                out_zero_reg, out_zero_next;
    logic                                out_load;
    logic [srca_pkg::SUM_W:0]            sum_wide;
    logic [srca_pkg::COUNT_BITS:0]       count_inc;

    assign sum_wide  = {1'b0, sum_reg} + (srca_pkg::SUM_W + 1)'(div_rsp.quotient);
    assign count_inc = {1'b0, count_reg} + (srca_pkg::COUNT_BITS + 1)'(1);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        zero_next      = zero_reg;
        out_edge_next  = out_edge_reg;
        out_zero_next  = out_zero_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (state_reg)
            srca_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    if (q_data.weighted && !q_data.zero_cost) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = srca_pkg::DIV_W'(
                            {q_data.numer, {(srca_pkg::FRAC_BITS - 1){1'b0}}});
                        div_req.divisor  = srca_pkg::DVS_W'(q_data.cost);
                        state_next       = srca_pkg::BK_TERM;
                    end else begin
                        state_next = srca_pkg::BK_POST;
                    end
                end
            end
            srca_pkg::BK_TERM: begin
                if (div_rsp.done) begin
                    sum_next   = sum_wide[srca_pkg::SUM_W] ? srca_pkg::SUM_MAX
                                                           : sum_wide[srca_pkg::SUM_W-1:0];
                    state_next = srca_pkg::BK_POST;
                end
            end
            srca_pkg::BK_POST: begin
                if (cmd_reg.weighted && cmd_reg.zero_cost) begin
                    zero_next = 1'b1;
                end
                if (cmd_reg.kind == srca_pkg::FUNC_CROSS &&
                    count_reg != srca_pkg::COUNT_MAX) begin
                    count_next = count_inc[srca_pkg::COUNT_BITS-1:0];
                end
                if (cmd_reg.kind == srca_pkg::FUNC_END) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = srca_pkg::DIV_W'(
                        sum_reg[srca_pkg::SUM_W-1:srca_pkg::FRAC_BITS]);
                    div_req.divisor  = (count_reg != '0) ? srca_pkg::DVS_W'(count_inc)
                                                         : srca_pkg::DVS_W'(2);
                    state_next       = srca_pkg::BK_MEAN;
                end else begin
                    state_next = srca_pkg::BK_IDLE;
                end
            end
            srca_pkg::BK_MEAN: begin
                if (div_rsp.done) begin
                    state_next = srca_pkg::BK_OUT;
                end
            end
            srca_pkg::BK_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_edge_next  = (div_rsp.quotient > srca_pkg::DIV_W'(srca_pkg::EDGE_MAX))
                                   ? srca_pkg::EDGE_MAX
                                   : div_rsp.quotient[srca_pkg::EDGE_W-1:0];
                    out_zero_next  = zero_reg;
                    sum_next       = '0;
                    count_next     = '0;
                    zero_next      = 1'b0;
                    state_next     = srca_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = srca_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srca_pkg::BK_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        out_edge_reg <= out_edge_next;
        out_zero_reg <= out_zero_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_edge_reg;
    assign m_tuser  = out_zero_reg;

    // The divider answers only while the back end waits for it.
    `SRCA_ASSERT_IMP(a_div_done_waited, aclk, aresetn, div_rsp.done, (state_reg == srca_pkg::BK_TERM) || (state_reg == srca_pkg::BK_MEAN))
    // Loading a result clears the segment state.
    `SRCA_ASSERT_NXT(a_clear_on_load, aclk, aresetn, out_load, (sum_reg == '0) && (count_reg == '0) && !zero_reg && m_tvalid)
    // The sum only grows between segment ends.
    `SRCA_ASSERT_NXT(a_sum_monotonic, aclk, aresetn, !out_load, sum_reg >= $past(sum_reg))
    // A crossed cell below the count limit bumps the count by one.
    `SRCA_ASSERT_NXT(a_count_step, aclk, aresetn, (state_reg == srca_pkg::BK_POST) && (cmd_reg.kind == srca_pkg::FUNC_CROSS) && (count_reg != srca_pkg::COUNT_MAX), count_reg == $past(count_reg) + 1'b1)

endmodule

// File: sv/semantic_ray_cost_accumulator_core.sv
// Semantic ray cost accumulator: top level tying front end, queue, back end
// and the shared divider together. Depends on srca_pkg and all srca_* modules.
//
// Usage: send the cells a line-of-sight segment crosses (func 0), then its
// start cell (func 1), then its end cell (func 2) on the s_ channel. Each
// weighted cell with nonzero cost adds weight_coef * multiplier / cell_cost
// with 16 fraction bits; the end cell returns the truncated mean on the m_
// channel and clears the segment. The cfg_ channel writes weight_coef
// (reset value 10); write it only while no segment is in flight.
// Timing: the shared two-bit-per-cycle divider sets the pace. A weighted
// cell with nonzero cost waits in TERM for its term from the divider and
// then passes POST; any other cell goes from IDLE straight to POST. An end
// cell then waits in MEAN for the mean division and in OUT for a free output
// register, which raises m_tvalid. The front end takes a transfer whenever
// the 4-entry queue has room, so up to four cells wait while the divider works.
// Reset (aresetn low, synchronous) clears the sum, count, flag, queue and
// the output valid flag; weight_coef returns to 10.
// Stall: a result held in the output register waits for m_tready while the
// back end goes on with the next segment; it stops only when the next
// result is ready and the register is still full.
module semantic_ray_cost_accumulator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [srca_pkg::COEF_W-1:0]   cfg_data,   // weight_coef[9:0]
    output logic                          cfg_ready,
    input  logic                          s_tvalid,
    input  logic [23:0]                   s_tdata,    // cell_class[3:0], cell_cost[19:4]
    input  logic [srca_pkg::FUNC_W-1:0]   s_tuser,    // func[1:0]
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srca_pkg::EDGE_W-1:0]   m_tdata,    // edge_cost[23:0]
    output logic                          m_tuser     // zero_cost_seen[0]
);

    // Front to queue.
    logic                q_push;
    logic                q_full;
    srca_pkg::cell_cmd_t q_push_data;

    // Queue to back end.
    logic                q_pop;
    logic                q_empty;
    srca_pkg::cell_cmd_t q_pop_data;

    // Back end to divider.
    srca_pkg::div_req_t  div_req;
    srca_pkg::div_rsp_t  div_rsp;

    // Classify cells and hold the weight register.
    srca_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cfg_ready   (cfg_ready),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tready    (s_tready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // Decouple the two sides so each can stall on its own.
    srca_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Accumulate terms and produce one result per segment.
    srca_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One divider serves both the cell terms and the segment mean.
    srca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule
